// File: hdl/csv_field_tokenizer_assert.svh
// Assertion macros for the CSV field tokenizer.
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that a property holds at every rising edge outside reset.
`define CSVT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("csv_field_tokenizer: assertion failed");
// Check that a condition never holds outside reset.
`define CSVT_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("csv_field_tokenizer: forbidden condition seen");
`else
`define CSVT_ASSERT(label, clk, rst, prop)
`define CSVT_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// File: hdl/csvt_pkg.sv
// Shared types and constants of the CSV field tokenizer.
`timescale 1ns / 1ps
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_COMMA = 2'd1;
  localparam logic [1:0] KIND_LINE  = 2'd2;
  localparam logic [1:0] KIND_EOT   = 2'd3;

  // paddr[2] selects the register word
  localparam logic REG_MAX_FIELD_BYTES = 1'b0;

  typedef enum logic [2:0] {
    MODE_LINE_START,
    MODE_FIELD_START,
    MODE_QUOTED,
    MODE_QUOTE_PENDING,
    MODE_UNQUOTED,
    MODE_SKIP_LF
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_BYTE
  } state_t;

  typedef struct packed {
    logic [7:0] field_byte;
    logic [1:0] kind;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic accept;
    logic flush_push;
    logic byte_push;
  } cmd_t;

  typedef struct packed {
    logic emit_one;
    logic flush_needed;
    logic flush_last;
  } stat_t;

endpackage

// File: hdl/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer: controller, datapath, output queue, APB register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata text_byte[7:0]; tuser end_of_text
//  m_*     | out | m_tvalid/m_tready  | tdata field_byte[7:0]; tuser kind[1:0]; tlast run_last
//  apb     | in  | psel/penable       | register 0 max_field_bytes[5:0] at byte address 0
//
// A word with at most one result is pushed as it is taken; one that flushes n held blanks
// starts the flush sequencer: it pushes the blanks, then the byte, one a cycle unless full.
// Reset (rst, synchronous) returns to line start with empty counters and an empty queue;
// max_field_bytes returns to MAX_FIELD_BYTES, capped at 63.
// A two-word output queue parts the streams: input is taken while a result waits. A full
// queue stalls the input side, and so does a running flush until its last word is pushed.
`timescale 1ns / 1ps
`include "csv_field_tokenizer_assert.svh"
module csv_field_tokenizer #(
  parameter int unsigned MAX_FIELD_BYTES = 63
) (
  input  logic        clk,
  input  logic        rst,
  // text stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic [0:0]  s_tuser,   // [0] end_of_text
  // field stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] field_byte
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // the field count register holds six bits, so cap the reset value there
  localparam logic [5:0] RESET_MAX =
    (MAX_FIELD_BYTES > 63) ? 6'd63 : MAX_FIELD_BYTES[5:0];

  csvt_pkg::cmd_t  cmd;
  csvt_pkg::stat_t stat;
  csvt_pkg::res_t  push_data;
  csvt_pkg::res_t  m_word;
  logic            push;
  logic            fifo_full;
  logic            cfg_we;
  logic [5:0]      max_field_bytes;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == csvt_pkg::REG_MAX_FIELD_BYTES);
  assign prdata = (paddr[2] == csvt_pkg::REG_MAX_FIELD_BYTES) ?
                  {26'd0, max_field_bytes} : 32'd0;

  csvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .fifo_full (fifo_full),
    .stat      (stat),
    .cmd       (cmd)
  );

  csvt_datapath #(
    .RESET_MAX (RESET_MAX)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .text_byte       (s_tdata),
    .end_of_text     (s_tuser[0]),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_data        (pwdata[5:0]),
    .max_field_bytes (max_field_bytes),
    .push            (push),
    .push_data       (push_data)
  );

  csvt_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_word    (m_word)
  );

  assign m_tdata = m_word.field_byte;
  assign m_tuser = m_word.kind;
  assign m_tlast = m_word.run_last;

  // a new text word never lands while a flush is still being pushed
  `CSVT_ASSERT_NEVER(a_accept_during_flush, clk, rst, cmd.accept && (cmd.flush_push || cmd.byte_push))
  // a single-result word leaves a word ready on the result side
  `CSVT_ASSERT(a_emit_one_shows, clk, rst, (cmd.accept && stat.emit_one) |=> m_tvalid)
  // the byte closing a flush always reaches the queue
  `CSVT_ASSERT(a_flush_byte_shows, clk, rst, cmd.byte_push |=> m_tvalid)

endmodule

// File: hdl/csvt_out_fifo.sv
// Two-word output queue between the tokenizer datapath and the result stream.
`timescale 1ns / 1ps
module csvt_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  csvt_pkg::res_t  push_data,
  output logic            full,
  output logic            m_tvalid,
  input  logic            m_tready,
  output csvt_pkg::res_t  m_word
);

  csvt_pkg::res_t entries [2];
  logic           head;
  logic           tail;
  logic [1:0]     count;
  logic           pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  assign full     = (count == 2'd2);
  assign m_word   = entries[head];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: hdl/csvt_ctrl.sv
// Sequencing controller: accepts text words and steps through blank flushes.
`timescale 1ns / 1ps
module csvt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic            fifo_full,
  input  csvt_pkg::stat_t stat,
  output csvt_pkg::cmd_t  cmd
);

  csvt_pkg::state_t state;
  csvt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csvt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      csvt_pkg::ST_IDLE: begin
        if (s_tvalid && !fifo_full && stat.flush_needed) begin
          state_next = csvt_pkg::ST_FLUSH;
        end
      end
      csvt_pkg::ST_FLUSH: begin
        if (!fifo_full && stat.flush_last) begin
          state_next = csvt_pkg::ST_BYTE;
        end
      end
      csvt_pkg::ST_BYTE: begin
        if (!fifo_full) begin
          state_next = csvt_pkg::ST_IDLE;
        end
      end
      default: state_next = csvt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.flush_push = 1'b0;
    cmd.byte_push  = 1'b0;
    case (state)
      csvt_pkg::ST_IDLE: begin
        s_tready   = !fifo_full;
        cmd.accept = s_tvalid && !fifo_full;
      end
      csvt_pkg::ST_FLUSH: cmd.flush_push = !fifo_full;
      csvt_pkg::ST_BYTE:  cmd.byte_push  = !fifo_full;
      default: ;
    endcase
  end

endmodule

// File: hdl/csvt_datapath.sv
// Tokenizer datapath: parse mode, field counters, held blanks and result mux.
`timescale 1ns / 1ps
module csvt_datapath #(
  parameter logic [5:0] RESET_MAX = 6'd63
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      text_byte,
  input  logic            end_of_text,
  input  csvt_pkg::cmd_t  cmd,
  output csvt_pkg::stat_t stat,
  input  logic            cfg_we,
  input  logic [5:0]      cfg_data,
  output logic [5:0]      max_field_bytes,
  output logic            push,
  output csvt_pkg::res_t  push_data
);

  csvt_pkg::mode_t mode;
  logic [5:0]      stored_count;
  logic [5:0]      held_blanks;
  logic [63:0]     blank_bytes;
  logic            content_started;
  logic [5:0]      flush_idx;
  logic [7:0]      pending_byte;

  csvt_pkg::mode_t mode_next;
  logic [5:0]      stored_count_next;
  logic [5:0]      held_blanks_next;
  logic [63:0]     blank_bytes_next;
  logic            content_started_next;

  logic            act_end;
  logic [1:0]      act_kind;
  logic            act_keep;
  logic            act_clear;
  logic            is_blank;
  logic            keep_ok;
  logic            keep_content;

  // decode one text word against the current parse mode
  always_comb begin
    act_end   = 1'b0;
    act_kind  = csvt_pkg::KIND_DATA;
    act_keep  = 1'b0;
    act_clear = 1'b0;
    mode_next = mode;
    if (end_of_text) begin
      act_end   = (mode != csvt_pkg::MODE_LINE_START) && (mode != csvt_pkg::MODE_SKIP_LF);
      act_kind  = csvt_pkg::KIND_EOT;
      act_clear = 1'b1;
      mode_next = csvt_pkg::MODE_LINE_START;
    end else begin
      case (mode)
        csvt_pkg::MODE_LINE_START, csvt_pkg::MODE_FIELD_START,
        csvt_pkg::MODE_QUOTE_PENDING, csvt_pkg::MODE_UNQUOTED: begin
          if (text_byte == csvt_pkg::CH_QUOTE &&
              (mode == csvt_pkg::MODE_LINE_START || mode == csvt_pkg::MODE_FIELD_START)) begin
            mode_next = csvt_pkg::MODE_QUOTED;
          end else if (text_byte == csvt_pkg::CH_QUOTE &&
                       mode == csvt_pkg::MODE_QUOTE_PENDING) begin
            act_keep  = 1'b1;
            mode_next = csvt_pkg::MODE_QUOTED;
          end else if (text_byte == csvt_pkg::CH_COMMA) begin
            act_end   = 1'b1;
            act_kind  = csvt_pkg::KIND_COMMA;
            act_clear = 1'b1;
            mode_next = csvt_pkg::MODE_FIELD_START;
          end else if (text_byte == csvt_pkg::CH_CR) begin
            act_end   = 1'b1;
            act_kind  = csvt_pkg::KIND_LINE;
            act_clear = 1'b1;
            mode_next = csvt_pkg::MODE_SKIP_LF;
          end else if (text_byte == csvt_pkg::CH_LF) begin
            act_end   = 1'b1;
            act_kind  = csvt_pkg::KIND_LINE;
            act_clear = 1'b1;
            mode_next = csvt_pkg::MODE_LINE_START;
          end else begin
            act_keep  = 1'b1;
            mode_next = csvt_pkg::MODE_UNQUOTED;
          end
        end
        csvt_pkg::MODE_QUOTED: begin
          if (text_byte == csvt_pkg::CH_QUOTE) begin
            mode_next = csvt_pkg::MODE_QUOTE_PENDING;
          end else begin
            act_keep = 1'b1;
          end
        end
        csvt_pkg::MODE_SKIP_LF: begin
          if (text_byte == csvt_pkg::CH_LF) begin
            mode_next = csvt_pkg::MODE_LINE_START;
          end
        end
        default: begin
          act_clear = 1'b1;
          mode_next = csvt_pkg::MODE_LINE_START;
        end
      endcase
    end
  end

  assign is_blank     = (text_byte == csvt_pkg::CH_SPACE) || (text_byte == csvt_pkg::CH_TAB);
  assign keep_ok      = act_keep && (stored_count < max_field_bytes);
  assign keep_content = keep_ok && !is_blank;

  assign stat.emit_one     = act_end || (keep_content && held_blanks == 6'd0);
  assign stat.flush_needed = keep_content && held_blanks != 6'd0;
  assign stat.flush_last   = (flush_idx == held_blanks - 6'd1);

  // field bookkeeping on an accepted word; held blanks stay until flushed or the field ends
  always_comb begin
    stored_count_next    = stored_count;
    held_blanks_next     = held_blanks;
    blank_bytes_next     = blank_bytes;
    content_started_next = content_started;
    if (act_clear) begin
      stored_count_next    = 6'd0;
      held_blanks_next     = 6'd0;
      blank_bytes_next     = 64'd0;
      content_started_next = 1'b0;
    end else if (keep_ok) begin
      stored_count_next = stored_count + 6'd1;
      if (is_blank) begin
        if (content_started) begin
          blank_bytes_next[held_blanks] = (text_byte == csvt_pkg::CH_TAB);
          held_blanks_next              = held_blanks + 6'd1;
        end
      end else begin
        content_started_next = 1'b1;
      end
    end
  end

  assign push = (cmd.accept && stat.emit_one) || cmd.flush_push || cmd.byte_push;

  always_comb begin
    if (cmd.flush_push) begin
      push_data.field_byte = blank_bytes[flush_idx] ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE;
      push_data.kind       = csvt_pkg::KIND_DATA;
      push_data.run_last   = 1'b0;
    end else if (cmd.byte_push) begin
      push_data.field_byte = pending_byte;
      push_data.kind       = csvt_pkg::KIND_DATA;
      push_data.run_last   = 1'b1;
    end else if (act_end) begin
      push_data.field_byte = 8'd0;
      push_data.kind       = act_kind;
      push_data.run_last   = 1'b1;
    end else begin
      push_data.field_byte = text_byte;
      push_data.kind       = csvt_pkg::KIND_DATA;
      push_data.run_last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pending_byte <= text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= csvt_pkg::MODE_LINE_START;
      stored_count    <= 6'd0;
      held_blanks     <= 6'd0;
      blank_bytes     <= 64'd0;
      content_started <= 1'b0;
      flush_idx       <= 6'd0;
      max_field_bytes <= RESET_MAX;
    end else begin
      if (cfg_we) begin
        max_field_bytes <= cfg_data;
      end
      if (cmd.accept) begin
        mode            <= mode_next;
        stored_count    <= stored_count_next;
        held_blanks     <= held_blanks_next;
        blank_bytes     <= blank_bytes_next;
        content_started <= content_started_next;
      end
      if (cmd.flush_push) begin
        flush_idx <= flush_idx + 6'd1;
      end
      if (cmd.byte_push) begin
        flush_idx   <= 6'd0;
        held_blanks <= 6'd0;
        blank_bytes <= 64'd0;
      end
    end
  end

endmodule

// File: sim/csv_field_tokenizer_tb.sv
// Self-checking testbench for the CSV field tokenizer: streams text words, checks field words.
`timescale 1ns / 1ps
module csv_field_tokenizer_tb;

  // Give up long after the slowest legal run would have finished.
  localparam int unsigned CYCLE_LIMIT = 3000000;
  // A flush of n held blanks stalls the text side until all are pushed; cover the worst case.
  localparam int unsigned SETTLE_CYCLES = 80;
  // Receiver hold-off long enough to back the output queue up into the text side.
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [2:0] LIMIT_ADDR = {csvt_pkg::REG_MAX_FIELD_BYTES, 2'b00};

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    bit         drain_first;  // hold this word back until every field word has come out
  } text_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] text_byte
  logic [0:0]  s_tuser = '0;   // [0] end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] field_byte
  logic [1:0]  m_tuser;        // [1:0] kind
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Tokenizer state as the testbench sees it.
  csvt_pkg::mode_t tok_mode = csvt_pkg::MODE_LINE_START;
  logic [5:0]  field_limit = 6'd63;
  logic [5:0]  kept_count = '0;
  logic [5:0]  blank_count = '0;
  logic [63:0] tab_mask = '0;
  logic        seen_content = 1'b0;

  csvt_pkg::res_t word_results[$];     // results of the word being parsed
  csvt_pkg::res_t expected_fields[$];  // field words still owed by the block
  text_word_t     text_q[$];           // text words waiting to be offered

  int unsigned words_queued = 0;
  int unsigned fields_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  logic        hold_start = 1'b0;
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;

  csv_field_tokenizer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void push_result(logic [7:0] ch, logic [1:0] kind);
    word_results.push_back('{field_byte: ch, kind: kind, run_last: 1'b0});
  endfunction

  function automatic void clear_field();
    kept_count   = '0;
    blank_count  = '0;
    tab_mask     = '0;
    seen_content = 1'b0;
  endfunction

  function automatic void close_field(logic [1:0] kind);
    push_result(8'h00, kind);
    clear_field();
  endfunction

  // Store one content byte, subject to the field limit. Leading blanks vanish; trailing
  // blanks wait until a later stored non-blank byte releases them in order.
  function automatic void keep_text_byte(logic [7:0] ch);
    int i;
    if (kept_count < field_limit) begin
      kept_count = kept_count + 6'd1;
      if (ch == csvt_pkg::CH_SPACE || ch == csvt_pkg::CH_TAB) begin
        if (seen_content) begin
          tab_mask[blank_count] = (ch == csvt_pkg::CH_TAB);
          blank_count = blank_count + 6'd1;
        end
      end else begin
        for (i = 0; i < blank_count; i++)
          push_result(tab_mask[i] ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE,
                      csvt_pkg::KIND_DATA);
        blank_count  = '0;
        tab_mask     = '0;
        seen_content = 1'b1;
        push_result(ch, csvt_pkg::KIND_DATA);
      end
    end
  endfunction

  // Handle a byte outside quotes: separators close the field, anything else is content.
  function automatic void take_unquoted(logic [7:0] ch);
    if (ch == csvt_pkg::CH_COMMA) begin
      close_field(csvt_pkg::KIND_COMMA);
      tok_mode = csvt_pkg::MODE_FIELD_START;
    end else if (ch == csvt_pkg::CH_CR) begin
      close_field(csvt_pkg::KIND_LINE);
      tok_mode = csvt_pkg::MODE_SKIP_LF;
    end else if (ch == csvt_pkg::CH_LF) begin
      close_field(csvt_pkg::KIND_LINE);
      tok_mode = csvt_pkg::MODE_LINE_START;
    end else begin
      keep_text_byte(ch);
      tok_mode = csvt_pkg::MODE_UNQUOTED;
    end
  endfunction

  // Advance the tokenizer by one accepted text word and queue the field words it owes.
  function automatic void parse_text_word(logic [7:0] ch, logic eot);
    word_results.delete();
    if (eot) begin
      // a field is open anywhere except at a line start or while skipping to LF
      if (tok_mode != csvt_pkg::MODE_LINE_START && tok_mode != csvt_pkg::MODE_SKIP_LF)
        close_field(csvt_pkg::KIND_EOT);
      clear_field();
      tok_mode = csvt_pkg::MODE_LINE_START;
    end else begin
      case (tok_mode)
        csvt_pkg::MODE_LINE_START, csvt_pkg::MODE_FIELD_START: begin
          if (ch == csvt_pkg::CH_QUOTE) tok_mode = csvt_pkg::MODE_QUOTED;
          else take_unquoted(ch);
        end
        csvt_pkg::MODE_QUOTED: begin
          if (ch == csvt_pkg::CH_QUOTE) tok_mode = csvt_pkg::MODE_QUOTE_PENDING;
          else keep_text_byte(ch);
        end
        csvt_pkg::MODE_QUOTE_PENDING: begin
          // a doubled quote stands for one quote; anything else runs on unquoted
          if (ch == csvt_pkg::CH_QUOTE) begin
            keep_text_byte(ch);
            tok_mode = csvt_pkg::MODE_QUOTED;
          end else begin
            take_unquoted(ch);
          end
        end
        csvt_pkg::MODE_UNQUOTED: take_unquoted(ch);
        csvt_pkg::MODE_SKIP_LF: begin
          if (ch == csvt_pkg::CH_LF) tok_mode = csvt_pkg::MODE_LINE_START;
        end
        default: begin
          tok_mode = csvt_pkg::MODE_LINE_START;
          clear_field();
        end
      endcase
    end
    if (word_results.size() != 0) word_results[word_results.size() - 1].run_last = 1'b1;
    foreach (word_results[i]) expected_fields.push_back(word_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_word(logic [7:0] ch, logic eot = 1'b0, bit drain = 1'b0);
    text_q.push_back('{ch: ch, eot: eot, drain_first: drain});
    words_queued++;
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) push_word(s[i]);
  endfunction

  function automatic void push_blank();
    push_word($urandom_range(0, 1) ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE);
  endfunction

  function automatic void queue_content(bit in_quotes);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) push_word(8'h61 + 8'($urandom_range(0, 25)));
    else if (r < 55) push_blank();
    else if (r < 56) repeat ($urandom_range(20, 60)) push_blank();  // long run to flush later
    else if (r < 70) push_word(8'($urandom));
    else if (r < 80) push_word(8'h30 + 8'($urandom_range(0, 9)));
    else if (!in_quotes) push_word(8'h41 + 8'($urandom_range(0, 25)));
    else if (r < 88) push_word(csvt_pkg::CH_COMMA);
    else if (r < 94) push_word($urandom_range(0, 1) ? csvt_pkg::CH_CR : csvt_pkg::CH_LF);
    else begin
      push_word(csvt_pkg::CH_QUOTE);
      push_word(csvt_pkg::CH_QUOTE);
    end
  endfunction

  function automatic void queue_field();
    int unsigned r;
    int unsigned len;
    bit          quoted;
    if ($urandom_range(0, 99) < 8) push_word(8'($urandom), $urandom_range(0, 9) == 0);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_blank();
    quoted = $urandom_range(0, 99) < 35;
    if (quoted) push_word(csvt_pkg::CH_QUOTE);
    r = $urandom_range(0, 99);
    if (r < 85) len = $urandom_range(0, 8);
    else if (r < 95) len = $urandom_range(9, 30);
    else len = $urandom_range(55, 70);
    repeat (len) queue_content(quoted);
    if (quoted) begin
      if ($urandom_range(0, 99) >= 5) push_word(csvt_pkg::CH_QUOTE);
      if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 3)) queue_content(1'b0);
    end
    if ($urandom_range(0, 99) < 4) push_word(8'($urandom), 1'b1);
  endfunction

  // Queue random records, some malformed, until at least target more words have been queued.
  task automatic queue_records(input int unsigned target);
    int unsigned first;
    int unsigned nf;
    int unsigned r;
    @(negedge clk);
    first = words_queued;
    while (words_queued - first < target) begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        if (f != 0) push_word(csvt_pkg::CH_COMMA);
        queue_field();
      end
      r = $urandom_range(0, 99);
      if (r < 45) push_word(csvt_pkg::CH_LF);
      else if (r < 65) begin
        push_word(csvt_pkg::CH_CR);
        push_word(csvt_pkg::CH_LF);
      end else if (r < 75) push_word(csvt_pkg::CH_CR);
      else if (r < 88) begin
        push_word(csvt_pkg::CH_CR);
        repeat ($urandom_range(1, 3)) push_word(8'($urandom));
        push_word(csvt_pkg::CH_LF);
      end else push_word(8'($urandom), 1'b1);
    end
  endtask

  // Wait until the text queue is empty and every field word is out, then let the
  // block settle so that no flush is still running.
  task automatic wait_drained();
    while (text_q.size() != 0 || s_tvalid || expected_fields.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the field limit over APB and read it straight back.
  task automatic set_field_limit(input logic [5:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    field_limit = value;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(value)) begin
      fail_count++;
      if (fail_count <= 10)
        $display("limit read-back: expected %0d, got %0d", value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset limit: leading and held blanks, a quoted field with
    // a comma and a doubled quote, skip to LF after CR, zero and all-ones bytes, an empty
    // field ended by comma, blanks before a quote, unclosed quote, and end of text in
    // field start, while skipping to LF and at a line start.
    @(negedge clk);
    push_text(" a \tb,");
    push_text("\",\"\"\"\r");
    push_word(csvt_pkg::CH_LF);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hFF);
    push_word(csvt_pkg::CH_LF);
    push_word(csvt_pkg::CH_COMMA);
    push_word(8'($urandom), 1'b1);
    push_text(" \"");
    push_word(8'($urandom), 1'b1);
    push_word(csvt_pkg::CH_QUOTE);
    push_word(8'($urandom), 1'b1);
    push_word(csvt_pkg::CH_CR);
    push_word(8'($urandom), 1'b1);
    push_word(8'($urandom), 1'b1);
    queue_records(55);
    wait_drained();

    // Tightest useful limit: nearly every byte past the first is dropped.
    set_field_limit(6'd1);
    queue_records(30);
    wait_drained();

    // Zero limit keeps nothing; only the end marks come out.
    set_field_limit(6'd0);
    queue_records(20);
    wait_drained();

    // A middle limit with no idling on either side.
    set_field_limit(6'($urandom_range(2, 62)));
    @(negedge clk);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    queue_records(55);
    wait_drained();

    // Full limit; hold the receiver off while the sender keeps pushing, so the output
    // queue fills and the text side stalls.
    set_field_limit(6'd63);
    @(negedge clk);
    receiver_idles = 1'b1;
    queue_records(60);
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    wait_drained();

    set_field_limit(6'($urandom_range(2, 62)));
    @(negedge clk);
    sender_idles = 1'b1;
    queue_records(25);
    wait_drained();

    if (fail_count == 0) begin
      $display("csv_field_tokenizer_tb: done, clean");
    end else begin
      $display("csv_field_tokenizer_tb: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Text driver: predict each accepted word, then offer the next, after a random gap when idling.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    text_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) parse_text_word(s_tdata, s_tuser[0]);
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (text_q.size() != 0 &&
                     !(text_q[0].drain_first && expected_fields.size() != 0)) begin
          w = text_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= w.ch;
          s_tuser  <= w.eot;
          send_gap <= sender_idles ? gap_len() : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here and obeyed by the field monitor.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Field monitor: compare each accepted field word with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    csvt_pkg::res_t got;
    csvt_pkg::res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{field_byte: m_tdata, kind: m_tuser, run_last: m_tlast};
        if (expected_fields.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("field word %0d unexpected: byte %02h kind %0d last %0d",
                     fields_seen, got.field_byte, got.kind, got.run_last);
        end else begin
          want = expected_fields.pop_front();
          if (got.field_byte !== want.field_byte || got.kind !== want.kind ||
              got.run_last !== want.run_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("field word %0d: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                       fields_seen, want.field_byte, want.kind, want.run_last,
                       got.field_byte, got.kind, got.run_last);
          end
        end
        fields_seen++;
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (receiver_idles && $urandom_range(0, 3) == 0) recv_gap <= gap_len();
      end
    end
  end

  // Watchdog: drop out with a failure if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("csv_field_tokenizer_tb: done, errors");
      $finish;
    end
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/csvt_pkg.sv
hdl/csvt_out_fifo.sv
hdl/csvt_ctrl.sv
hdl/csvt_datapath.sv
hdl/csv_field_tokenizer.sv
sim/csv_field_tokenizer_tb.sv
